// ===== sv/vzr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the multiply-accumulate step table of the voxel splat renderer.
package vzr_pkg;

  localparam int MAX_GRID   = 64;
  localparam int MAX_LAYERS = 128;
  localparam int MAX_FRAME  = 64;

  localparam int VXY_W   = $clog2(MAX_GRID);
  localparam int VZ_W    = $clog2(MAX_LAYERS);
  localparam int PIX_W   = $clog2(MAX_FRAME);
  localparam int ADDR_W  = 2 * PIX_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam int CFG_W     = 16;
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;
  localparam int PAL_W     = 8;
  localparam int DEPTH_W   = 32;

  localparam int MX_W  = ((VXY_W + 1 > SIZE_W) ? VXY_W + 1 : SIZE_W) + 2;
  localparam int MZ_W  = VZ_W + 2;
  localparam int A_W   = MX_W + CFG_W;
  localparam int B_W   = CFG_W;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 3;
  localparam int CW    = (PIX_W + 1 > SIZE_W) ? PIX_W + 1 : SIZE_W;

  localparam int FRAC_H = 15;
  localparam int FRAC_V = 29;
  localparam int ELEV_SHIFT = 14;
  localparam int ANCH_H_SHIFT = 7;
  localparam int ANCH_V_SHIFT = 21;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_SPLAT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_YAW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_YAW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_ELEV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_ELEV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_H   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_V   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 3'd7;

  localparam logic signed [CFG_W-1:0] RST_COS_YAW  = 16'sd16384;
  localparam logic signed [CFG_W-1:0] RST_SIN_YAW  = 16'sd0;
  localparam logic signed [CFG_W-1:0] RST_SIN_ELEV = 16'sd16384;
  localparam logic signed [CFG_W-1:0] RST_COS_ELEV = 16'sd0;
  localparam logic [CFG_W-1:0]  RST_ANCHOR  = 16'd8192;
  localparam logic [SIZE_W-1:0] RST_SIZE    = 7'd64;

  localparam logic [2:0] A_MX  = 3'd0;
  localparam logic [2:0] A_MY  = 3'd1;
  localparam logic [2:0] A_MZ  = 3'd2;
  localparam logic [2:0] A_ACC = 3'd3;
  localparam logic [2:0] A_RY  = 3'd4;

  localparam logic [1:0] B_CY = 2'd0;
  localparam logic [1:0] B_SY = 2'd1;
  localparam logic [1:0] B_SE = 2'd2;
  localparam logic [1:0] B_CE = 2'd3;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [1:0] b_sel;
    logic       sub;
    logic       shift;
  } mac_step_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic sub;
    logic shift;
  } mac_ctl_t;

  typedef struct packed {
    logic                      valid;
    logic [PAL_W-1:0]          colour;
    logic signed [DEPTH_W-1:0] depth;
  } mem_entry_t;

  // Pairs of products: horizontal sum, rotated y, vertical sum, depth.
  function automatic mac_step_t mac_step(input logic [2:0] step);
    mac_step_t s;
    unique case (step)
      3'd0:    s = '{a_sel: A_MX,  b_sel: B_CY, sub: 1'b0, shift: 1'b0};
      3'd1:    s = '{a_sel: A_MY,  b_sel: B_SY, sub: 1'b1, shift: 1'b0};
      3'd2:    s = '{a_sel: A_MX,  b_sel: B_SY, sub: 1'b0, shift: 1'b0};
      3'd3:    s = '{a_sel: A_MY,  b_sel: B_CY, sub: 1'b0, shift: 1'b0};
      3'd4:    s = '{a_sel: A_ACC, b_sel: B_SE, sub: 1'b0, shift: 1'b0};
      3'd5:    s = '{a_sel: A_MZ,  b_sel: B_CE, sub: 1'b1, shift: 1'b1};
      3'd6:    s = '{a_sel: A_RY,  b_sel: B_CE, sub: 1'b0, shift: 1'b0};
      3'd7:    s = '{a_sel: A_MZ,  b_sel: B_SE, sub: 1'b0, shift: 1'b1};
      default: s = '{a_sel: A_MX,  b_sel: B_CY, sub: 1'b0, shift: 1'b0};
    endcase
    return s;
  endfunction

endpackage

// ===== sv/vzr_mac.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product and a wide accumulator.
module vzr_mac (
  input  logic                              clk,
  input  vzr_pkg::mac_ctl_t                 ctl,
  input  logic signed [vzr_pkg::A_W-1:0]    a,
  input  logic signed [vzr_pkg::B_W-1:0]    b,
  input  logic signed [vzr_pkg::ACC_W-1:0]  base,
  output logic signed [vzr_pkg::ACC_W-1:0]  acc
);
  import vzr_pkg::*;

  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] origin;
  logic signed [ACC_W-1:0] acc_next;

  always_comb begin
    term     = ctl.shift ? (ACC_W'(prod) <<< ELEV_SHIFT) : ACC_W'(prod);
    origin   = ctl.first ? base : acc;
    acc_next = ctl.sub ? origin - term : origin + term;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== sv/vzr_frame_mem.sv =====
`timescale 1ns / 1ps
// Frame store: valid mark, palette index and depth per pixel, one write and one read port.
module vzr_frame_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [vzr_pkg::ADDR_W-1:0]   wr_addr,
  input  vzr_pkg::mem_entry_t          wr_data,
  input  logic                         rd_en,
  input  logic [vzr_pkg::ADDR_W-1:0]   rd_addr,
  output vzr_pkg::mem_entry_t          rd_data
);
  import vzr_pkg::*;

  mem_entry_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/voxel_zbuffer_splat_renderer_unit.sv =====
`timescale 1ns / 1ps
// Top level: sequencer, configuration registers, projection and z-buffer update.
// Splat: eight products on the shared multiply-accumulate unit (a multiply state and
//   an accumulate state each), one bounds check, one depth read-modify-write; done.
// Read: one registered memory read, then done. Clear: a sweep over all 4096 entries,
//   then done. Rejected items: done straight from idle; off-frame splats: done from
//   the bounds check. Busy until done; next start taken with done.
// Reset: registers load their defaults, then all 4096 frame store entries are emptied.
module voxel_zbuffer_splat_renderer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [vzr_pkg::OP_W-1:0]          operation,
  input  logic [vzr_pkg::VXY_W-1:0]         vox_x,
  input  logic [vzr_pkg::VXY_W-1:0]         vox_y,
  input  logic [vzr_pkg::VZ_W-1:0]          vox_z,
  input  logic                              occupied,
  input  logic [vzr_pkg::PAL_W-1:0]         palette_index,
  input  logic [vzr_pkg::PIX_W-1:0]         pixel_x,
  input  logic [vzr_pkg::PIX_W-1:0]         pixel_y,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vzr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vzr_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic [vzr_pkg::PAL_W-1:0]         result_index,
  output logic                              in_frame,
  output logic                              won_depth
);
  import vzr_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;

  localparam int PX_W = ACC_W - FRAC_H;
  localparam int PY_W = ACC_W - FRAC_V;

  logic [2:0] state;
  logic [2:0] step;
  logic [ADDR_W-1:0] clr_addr;
  logic clr_report;

  logic signed [CFG_W-1:0] cos_yaw, sin_yaw, sin_elev, cos_elev;
  logic [CFG_W-1:0] anchor_h, anchor_v;
  logic [SIZE_W-1:0] grid_size, frame_size;

  logic signed [MX_W-1:0] mx2, my2;
  logic signed [MZ_W-1:0] mz2;
  logic [PAL_W-1:0] pal;
  logic signed [ACC_W-1:0] fx, fy;
  logic signed [A_W-1:0] ry;
  logic signed [DEPTH_W-1:0] depth;
  logic [ADDR_W-1:0] sp_addr;

  logic [CW-1:0] fs;
  logic vox_ok, rd_ok;
  logic signed [MX_W-1:0] mx2_in, my2_in;
  logic signed [MZ_W-1:0] mz2_in;
  mac_step_t st;
  mac_ctl_t mctl;
  logic signed [A_W-1:0] a_op;
  logic signed [B_W-1:0] b_op;
  logic signed [ACC_W-1:0] base, acc;
  logic signed [PX_W-1:0] px;
  logic signed [PY_W-1:0] py;
  logic signed [PX_W-1:0] nr_floor;
  logic px_ok, py_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic win;

  logic mem_we, mem_rd_en;
  logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
  mem_entry_t mem_wr_data, mem_rd_data;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    fs = (CW'(frame_size) > CW'(MAX_FRAME)) ? CW'(MAX_FRAME) : CW'(frame_size);
    vox_ok = occupied && (MX_W'(vox_x) < MX_W'(grid_size))
             && (MX_W'(vox_y) < MX_W'(grid_size))
             && ((VZ_W + 1)'(vox_z) < (VZ_W + 1)'(MAX_LAYERS));
    rd_ok  = (CW'(pixel_x) < fs) && (CW'(pixel_y) < fs);
    mx2_in = $signed({{(MX_W - VXY_W - 1){1'b0}}, vox_x, 1'b1})
             - $signed(MX_W'(grid_size));
    my2_in = $signed({{(MX_W - VXY_W - 1){1'b0}}, vox_y, 1'b1})
             - $signed(MX_W'(grid_size));
    mz2_in = $signed({1'b0, vox_z, 1'b1});
  end

  always_comb begin
    st = mac_step(step);
    mctl.mul_en = (state == S_MUL);
    mctl.acc_en = (state == S_ACC);
    mctl.first  = !step[0];
    mctl.sub    = st.sub;
    mctl.shift  = st.shift;
    case (st.a_sel)
      A_MX:    a_op = A_W'(mx2);
      A_MY:    a_op = A_W'(my2);
      A_MZ:    a_op = A_W'(mz2);
      A_ACC:   a_op = acc[A_W-1:0];
      default: a_op = ry;
    endcase
    case (st.b_sel)
      B_CY:    b_op = cos_yaw;
      B_SY:    b_op = sin_yaw;
      B_SE:    b_op = sin_elev;
      default: b_op = cos_elev;
    endcase
    if (step == 3'd0) begin
      base = $signed(ACC_W'({anchor_h, {ANCH_H_SHIFT{1'b0}}}));
    end else if (step == 3'd4) begin
      base = $signed(ACC_W'({anchor_v, {ANCH_V_SHIFT{1'b0}}}));
    end else begin
      base = '0;
    end
  end

  vzr_mac u_mac (
    .clk  (clk),
    .ctl  (mctl),
    .a    (a_op),
    .b    (b_op),
    .base (base),
    .acc  (acc)
  );

  always_comb begin
    px       = fx[ACC_W-1:FRAC_H];
    py       = fy[ACC_W-1:FRAC_V];
    nr_floor = acc[ACC_W-1:FRAC_H];
    px_ok    = !px[PX_W-1] && (px < $signed(PX_W'(fs)));
    py_ok    = !py[PY_W-1] && (py < $signed(PY_W'(fs)));
    pix_addr = {py[PIX_W-1:0], px[PIX_W-1:0]};
    win      = !mem_rd_data.valid || (depth > $signed(mem_rd_data.depth));
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_UPDATE && win) begin
      mem_we      = 1'b1;
      mem_wr_addr = sp_addr;
      mem_wr_data = '{valid: 1'b1, colour: pal, depth: depth};
    end
    mem_rd_en   = ((state == S_IDLE) && start && (operation == OP_READ) && rd_ok)
                  || (state == S_CHECK);
    mem_rd_addr = (state == S_IDLE) ? {pixel_y, pixel_x} : pix_addr;
  end

  vzr_frame_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_yaw    <= RST_COS_YAW;
      sin_yaw    <= RST_SIN_YAW;
      sin_elev   <= RST_SIN_ELEV;
      cos_elev   <= RST_COS_ELEV;
      anchor_h   <= RST_ANCHOR;
      anchor_v   <= RST_ANCHOR;
      grid_size  <= RST_SIZE;
      frame_size <= RST_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COS_YAW:    cos_yaw    <= cfg_data;
        CFG_SIN_YAW:    sin_yaw    <= cfg_data;
        CFG_SIN_ELEV:   sin_elev   <= cfg_data;
        CFG_COS_ELEV:   cos_elev   <= cfg_data;
        CFG_ANCHOR_H:   anchor_h   <= cfg_data;
        CFG_ANCHOR_V:   anchor_v   <= cfg_data;
        CFG_GRID_SIZE:  grid_size  <= cfg_data[SIZE_W-1:0];
        CFG_FRAME_SIZE: frame_size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload latches.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mx2 <= mx2_in;
      my2 <= my2_in;
      mz2 <= mz2_in;
      pal <= palette_index;
    end
    if (state == S_MUL) begin
      if (step == 3'd2) fx <= acc;
      if (step == 3'd4) ry <= acc[A_W-1:0];
      if (step == 3'd6) fy <= acc;
    end
    if (state == S_CHECK) begin
      depth   <= DEPTH_W'(nr_floor);
      sp_addr <= pix_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      step         <= '0;
      clr_addr     <= '0;
      clr_report   <= 1'b0;
      done         <= 1'b0;
      result_index <= '0;
      in_frame     <= 1'b0;
      won_depth    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              done         <= 1'b1;
              result_index <= '0;
              in_frame     <= 1'b0;
              won_depth    <= 1'b0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            if (operation == OP_CLEAR) begin
              state      <= S_CLEAR;
              clr_addr   <= '0;
              clr_report <= 1'b1;
            end else if (operation == OP_SPLAT && vox_ok) begin
              state <= S_MUL;
              step  <= '0;
            end else if (operation == OP_READ && rd_ok) begin
              state <= S_RDWAIT;
            end else begin
              done         <= 1'b1;
              result_index <= '0;
              in_frame     <= 1'b0;
              won_depth    <= 1'b0;
            end
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (step == 3'd7) begin
            state <= S_CHECK;
          end else begin
            step  <= step + 1'b1;
            state <= S_MUL;
          end
        end
        S_CHECK: begin
          if (px_ok && py_ok) begin
            state <= S_UPDATE;
          end else begin
            state        <= S_IDLE;
            done         <= 1'b1;
            result_index <= '0;
            in_frame     <= 1'b0;
            won_depth    <= 1'b0;
          end
        end
        S_UPDATE: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          result_index <= '0;
          in_frame     <= 1'b1;
          won_depth    <= win;
        end
        S_RDWAIT: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          result_index <= mem_rd_data.colour;
          in_frame     <= 1'b0;
          won_depth    <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_won_in_frame: assert property (@(posedge clk) disable iff (rst)
    won_depth |-> in_frame)
    else $error("depth win reported outside the frame");

  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither started nor completed");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

endmodule
